// ===== sv/octenc_pkg.sv =====
// ============================================================================
// Octahedral normal encoder package
// Shared widths and the record that travels down the divider chain.
// ============================================================================
package octenc_pkg;

  // Input component width, signed Q1.(COMP_BITS-1).
  localparam int COMP_BITS = 16;
  // Magnitude of one component, wide enough for the most negative value.
  localparam int MAG_W     = COMP_BITS + 1;
  // L1 norm: three magnitudes of at most 2^(COMP_BITS-1) stay below 2^(COMP_BITS+1).
  localparam int LEN_W     = COMP_BITS + 1;
  // Quotient bits: the rounded result never exceeds 127.
  localparam int Q_W       = 7;
  // Encoded snorm8 width.
  localparam int ENC_W     = 8;
  // Numerator 254*m + L stays below 256*L.
  localparam int NUM_W     = LEN_W + 8;
  // One restoring step per quotient bit.
  localparam int DIV_STEPS = Q_W;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W  = ((3 * COMP_BITS + 7) / 8) * 8;
  localparam int M_DATA_W  = ((2 * ENC_W + 7) / 8) * 8;

  // One item as it moves through the divider chain.
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] rem_u;   // partial remainder for u
    logic [NUM_W-1:0] rem_v;   // partial remainder for v
    logic [NUM_W-1:0] dsh;     // divisor 2L, aligned to the current bit
    logic [Q_W-1:0]   q_u;     // quotient bits gathered so far for u
    logic [Q_W-1:0]   q_v;     // quotient bits gathered so far for v
    logic             neg_u;
    logic             neg_v;
    logic             zero;
  } cell_t;

endpackage

// ===== sv/octahedral_normal_encoder.sv =====
// Inputs pass through three front-end stages, seven divider cells and one
// output register. Throughput: one vector per cycle unless the output
// stalls; each divider cell settles one quotient bit of u and v, so the
// chain of seven cells sets the depth.
// Reset: synchronous, clears every stage valid flag; the pipeline is empty.
// ============================================================================
// Octahedral normal encoder
// Encodes a signed direction vector into two snorm8 octahedral coordinates.
// ============================================================================
module octahedral_normal_encoder
  import octenc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // comp_x, comp_y, comp_z
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // enc_u, enc_v
  output logic                m_axis_tuser   // zero_vector
);

  cell_t                link       [0:DIV_STEPS];
  logic  [DIV_STEPS:0]  link_ready;
  logic                 out_ready;
  logic  [ENC_W-1:0]    enc_u, enc_v;
  logic                 zero_vector;
  cell_t                last;

  assign out_ready = !m_axis_tvalid || m_axis_tready;

  // Front end: magnitudes, norm, fold and numerators.
  octenc_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .comp_x     (s_axis_tdata[COMP_BITS-1:0]),
    .comp_y     (s_axis_tdata[2*COMP_BITS-1:COMP_BITS]),
    .comp_z     (s_axis_tdata[3*COMP_BITS-1:2*COMP_BITS]),
    .down       (link[0]),
    .down_ready (link_ready[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    octenc_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up         (link[i]),
      .up_ready   (link_ready[i]),
      .down       (link[i+1]),
      .down_ready (link_ready[i+1])
    );
  end

  assign link_ready[DIV_STEPS] = out_ready;
  assign last                  = link[DIV_STEPS];

  // Apply signs; a zero vector gives zero coordinates.
  always_comb begin
    zero_vector = last.zero;
    if (last.zero) begin
      enc_u = '0;
      enc_v = '0;
    end else begin
      enc_u = last.neg_u ? ENC_W'(0) - {1'b0, last.q_u} : {1'b0, last.q_u};
      enc_v = last.neg_v ? ENC_W'(0) - {1'b0, last.q_v} : {1'b0, last.q_v};
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= last.valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_ready) begin
      m_axis_tdata <= M_DATA_W'({enc_v, enc_u});
      m_axis_tuser <= zero_vector;
    end
  end

endmodule

// ===== sv/octenc_prep.sv =====
// ============================================================================
// Octahedral encoder front end
// Takes magnitudes, forms the L1 norm, folds the lower hemisphere and builds
// the numerator and aligned divisor for the divider chain, in three stages.
// ============================================================================
module octenc_prep
  import octenc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COMP_BITS-1:0] comp_x,
  input  logic [COMP_BITS-1:0] comp_y,
  input  logic [COMP_BITS-1:0] comp_z,
  output cell_t                down,
  input  logic                 down_ready
);

  // Stage A: magnitudes and signs.
  logic             a_valid;
  logic [MAG_W-1:0] a_ax, a_ay, a_az;
  logic             a_nx, a_ny, a_fold;
  logic             a_ready;

  // Stage B: norm and folded numerators.
  logic             b_valid;
  logic [LEN_W-1:0] b_len, b_mu, b_mv;
  logic             b_nx, b_ny;
  logic             b_ready;

  // Stage C output record.
  cell_t            c_reg;
  logic             c_ready;

  assign c_ready  = !c_reg.valid || down_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign down     = c_reg;

  // Stage A valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  // Stage A payload: two's complement to sign and magnitude.
  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_nx   <= comp_x[COMP_BITS-1];
      a_ny   <= comp_y[COMP_BITS-1];
      a_ax   <= comp_x[COMP_BITS-1] ? MAG_W'(0) - {1'b1, comp_x} : {1'b0, comp_x};
      a_ay   <= comp_y[COMP_BITS-1] ? MAG_W'(0) - {1'b1, comp_y} : {1'b0, comp_y};
      a_az   <= comp_z[COMP_BITS-1] ? MAG_W'(0) - {1'b1, comp_z} : {1'b0, comp_z};
      // A zero or negative z lies in the lower hemisphere.
      a_fold <= comp_z[COMP_BITS-1] || (comp_z == '0);
    end
  end

  // Stage B valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  // Stage B payload. L - |y| is |x| + |z|, so the fold needs no subtract.
  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_len <= LEN_W'(a_ax) + LEN_W'(a_ay) + LEN_W'(a_az);
      b_mu  <= a_fold ? LEN_W'(a_ax) + LEN_W'(a_az) : LEN_W'(a_ax);
      b_mv  <= a_fold ? LEN_W'(a_ay) + LEN_W'(a_az) : LEN_W'(a_ay);
      b_nx  <= a_nx;
      b_ny  <= a_ny;
    end
  end

  // Stage C record: valid flag, numerator 254*m + L and divisor 2L aligned
  // to the top quotient bit. The multiply by 254 is a shift and a subtract.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_reg.valid <= 1'b0;
    end else if (c_ready) begin
      c_reg.valid <= b_valid;
    end
    if (c_ready) begin
      c_reg.rem_u <= (NUM_W'(b_mu) << 8) - (NUM_W'(b_mu) << 1) + NUM_W'(b_len);
      c_reg.rem_v <= (NUM_W'(b_mv) << 8) - (NUM_W'(b_mv) << 1) + NUM_W'(b_len);
      c_reg.dsh   <= NUM_W'(b_len) << Q_W;
      c_reg.q_u   <= '0;
      c_reg.q_v   <= '0;
      c_reg.neg_u <= b_nx;
      c_reg.neg_v <= b_ny;
      c_reg.zero  <= (b_len == '0);
    end
  end

endmodule

// ===== sv/octenc_div_cell.sv =====
// ============================================================================
// Octahedral encoder divider cell
// One restoring division step for both coordinates: settles one quotient bit
// and hands the remainder and the halved divisor to the next cell.
// ============================================================================
module octenc_div_cell
  import octenc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cell_t up,
  output logic  up_ready,
  output cell_t down,
  input  logic  down_ready
);

  cell_t      cur;
  logic       ge_u, ge_v;

  assign up_ready = !cur.valid || down_ready;
  assign down     = cur;

  // Trial subtraction against the aligned divisor.
  assign ge_u = (up.rem_u >= up.dsh);
  assign ge_v = (up.rem_v >= up.dsh);

  // Valid flag and payload: keep or reduce the remainder and shift in the
  // quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (up_ready) begin
      cur.valid <= up.valid;
    end
    if (up_ready) begin
      cur.rem_u <= ge_u ? up.rem_u - up.dsh : up.rem_u;
      cur.rem_v <= ge_v ? up.rem_v - up.dsh : up.rem_v;
      cur.dsh   <= up.dsh >> 1;
      cur.q_u   <= {up.q_u[Q_W-2:0], ge_u};
      cur.q_v   <= {up.q_v[Q_W-2:0], ge_v};
      cur.neg_u <= up.neg_u;
      cur.neg_v <= up.neg_v;
      cur.zero  <= up.zero;
    end
  end

endmodule

// ===== test/octahedral_normal_encoder_tb.sv =====
// ============================================================================
// Octahedral normal encoder testbench
// Drives direction vectors into the encoder, works out the expected snorm8
// octahedral coordinates for every accepted transaction and compares each
// returned transaction with the oldest expectation. The sender idles and the
// receiver stalls at random, with one long receiver hold-off that fills the
// pipeline and stalls the input side.
// ============================================================================
module octahedral_normal_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import octenc_pkg::*;

  localparam int LATENCY     = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_VECS = 1380;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;

  // One direction vector; comp_x sits in the lowest bits when packed.
  typedef struct packed {
    logic signed [COMP_BITS-1:0] comp_z;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_x;
  } vec_t;

  // One encoded result.
  typedef struct packed {
    logic signed [ENC_W-1:0] enc_u;
    logic signed [ENC_W-1:0] enc_v;
    logic                    zero_vector;
  } coord_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;   // comp_x, comp_y, comp_z
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;        // enc_u, enc_v
  logic                m_axis_tuser;        // zero_vector

  vec_t   pending_vecs[$];
  coord_t expected_coords[$];
  coord_t want_coord;
  int     total_vecs   = 0;
  int     accepted_cnt = 0;
  int     returned_cnt = 0;
  int     error_cnt    = 0;
  int     cycle_cnt    = 0;
  int     drv_taken    = 0;
  int     drv_gap      = 0;
  bit     drv_offering = 1'b0;
  int     stall_left   = 0;
  int     hold_left    = 0;
  bit     hold_done    = 1'b0;
  bit     rdy;

  octahedral_normal_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Scale a magnitude by 127/len, round half away from zero and apply the sign.
  function automatic logic signed [ENC_W-1:0] scale_round(longint mag, bit neg, longint len);
    longint q;
    q = (254 * mag + len) / (2 * len);
    if (q > 127) q = 127;
    if (neg) q = -q;
    return ENC_W'(q);
  endfunction

  // Expected encoding of one direction vector.
  function automatic coord_t octa_encode(vec_t v);
    longint ax, ay, az, len, mu, mv;
    coord_t r;
    ax  = longint'($signed(v.comp_x));
    ay  = longint'($signed(v.comp_y));
    az  = longint'($signed(v.comp_z));
    ax  = (ax < 0) ? -ax : ax;
    ay  = (ay < 0) ? -ay : ay;
    az  = (az < 0) ? -az : az;
    len = ax + ay + az;
    r   = '0;
    if (len == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    // A zero or negative z lies in the lower hemisphere and is folded.
    if ($signed(v.comp_z) <= 0) begin
      mu = len - ay;
      mv = len - ax;
    end else begin
      mu = ax;
      mv = ay;
    end
    r.enc_u = scale_round(mu, v.comp_x[COMP_BITS-1], len);
    r.enc_v = scale_round(mv, v.comp_y[COMP_BITS-1], len);
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long, none in quiet windows.
  function automatic int pick_gap(int progress);
    int r;
    if ((progress / 150) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int small_value();
    return int'($urandom_range(0, 8)) - 4;
  endfunction

  task automatic add_vec(int x, int y, int z);
    vec_t v;
    v.comp_x = COMP_BITS'(x);
    v.comp_y = COMP_BITS'(y);
    v.comp_z = COMP_BITS'(z);
    pending_vecs = {pending_vecs, v};
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_cnt++;
  endtask

  // Sender: offers the next pending vector after a random gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (drv_offering && accepted_cnt != drv_taken) begin
        drv_taken    = accepted_cnt;
        drv_offering = 1'b0;
        drv_gap      = pick_gap(accepted_cnt);
      end
      if (!drv_offering) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_vecs.size() > 0) begin
          s_axis_tdata <= S_DATA_W'(pending_vecs.pop_front());
          drv_offering = 1'b1;
        end
      end
      s_axis_tvalid <= drv_offering;
    end
  end

  // Receiver: random stalls, plus one long hold-off once traffic is flowing.
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(returned_cnt);
      end
      m_axis_tready <= rdy;
    end
  end

  // Input side: each accepted transaction adds its expected result.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_coords = {expected_coords,
                         octa_encode(vec_t'(s_axis_tdata[3*COMP_BITS-1:0]))};
      accepted_cnt++;
    end
  end

  // Output side: compare each returned transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      returned_cnt++;
      if (expected_coords.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, tdata %h tuser %b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want_coord = expected_coords.pop_front();
        if (m_axis_tdata[ENC_W-1:0] !== want_coord.enc_u)
          report_mismatch($sformatf("enc_u got %0d expected %0d",
                                    $signed(m_axis_tdata[ENC_W-1:0]), want_coord.enc_u));
        if (m_axis_tdata[2*ENC_W-1:ENC_W] !== want_coord.enc_v)
          report_mismatch($sformatf("enc_v got %0d expected %0d",
                                    $signed(m_axis_tdata[2*ENC_W-1:ENC_W]), want_coord.enc_v));
        if (m_axis_tuser !== want_coord.zero_vector)
          report_mismatch($sformatf("zero_vector got %b expected %b",
                                    m_axis_tuser, want_coord.zero_vector));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("octahedral_normal_encoder_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int kind;
    int x, y, z;

    // Directed vectors: zero vector, extremes, axes, z of zero and rounding ties.
    add_vec(0, 0, 0);
    add_vec(-32768, -32768, -32768);
    add_vec(32767, 32767, 32767);
    add_vec(-32768, 0, 0);
    add_vec(0, -32768, 0);
    add_vec(0, 0, -32768);
    add_vec(0, 0, 32767);
    add_vec(0, 0, 1);
    add_vec(1, 0, 0);
    add_vec(0, 1, 0);
    add_vec(100, -200, 0);
    add_vec(-1, -1, -1);
    add_vec(32767, -32768, 1);
    add_vec(-32768, 32767, -1);
    add_vec(1, 0, 253);
    add_vec(-1, 0, 253);
    add_vec(1, 0, -253);
    add_vec(0, -5, -10);
    add_vec(-5, 0, -10);
    add_vec(-32768, -32768, 32767);
    add_vec(12345, -23456, 0);
    add_vec(0, 0, 0);

    // Random vectors, weighted towards the interesting regions.
    for (int i = 0; i < RANDOM_VECS; i++) begin
      kind = $urandom_range(0, 9);
      case (kind) inside
        [0:3]: begin
          x = $signed(COMP_BITS'($urandom));
          y = $signed(COMP_BITS'($urandom));
          z = $signed(COMP_BITS'($urandom));
        end
        [4:5]: begin
          x = small_value();
          y = small_value();
          z = small_value();
        end
        6: begin
          x = edge_value();
          y = edge_value();
          z = edge_value();
        end
        7: begin
          x = small_value();
          y = $signed(COMP_BITS'($urandom));
          z = int'($urandom_range(1, 32767));
        end
        8: begin
          x = $signed(COMP_BITS'($urandom));
          y = $signed(COMP_BITS'($urandom));
          z = -int'($urandom_range(0, 32768));
        end
        default: begin
          x = edge_value();
          y = small_value();
          z = $signed(COMP_BITS'($urandom));
        end
      endcase
      add_vec(x, y, z);
    end
    total_vecs = pending_vecs.size();

    // Reset, released on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every vector to go in and every result to come back.
    while (accepted_cnt < total_vecs) @(posedge clk);
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (error_cnt == 0) begin
      $display("octahedral_normal_encoder_tb OK");
    end else begin
      $display("octahedral_normal_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== octahedral_normal_encoder.f =====
sv/octenc_pkg.sv
sv/octenc_prep.sv
sv/octenc_div_cell.sv
sv/octahedral_normal_encoder.sv
test/octahedral_normal_encoder_tb.sv
